[rtl/rskt_pkg.sv]
package rskt_pkg;

  localparam int Capacity = 256;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int EntW = 80;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_RAISED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_LOWERED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FOUND     = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] key;
    logic [31:0] data_handle;
    logic [15:0] entry_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_handle;
    logic [15:0] found_size;
  } rsp_t;

  // One stored entry: key, handle, size, reference count.
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] handle;
    logic [15:0] size;
    logic [15:0] refs;
  } entry_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic            load_req;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            hold_rd;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [1:0]      wr_sel;   // 0 entry just read, 1 new entry, 2 ref+1, 3 ref-1
    logic            cnt_inc;
    logic            cnt_dec;
    logic            rsp_load;
    logic [2:0]      rsp_status;
  } cmd_t;

  localparam logic [1:0] WS_MOVE = 2'd0;
  localparam logic [1:0] WS_NEW  = 2'd1;
  localparam logic [1:0] WS_INC  = 2'd2;
  localparam logic [1:0] WS_DEC  = 2'd3;

  // Datapath status to the controller.
  typedef struct packed {
    logic [1:0]      operation;
    logic [CntW-1:0] count;
    logic            rd_less;   // read entry key below request key
    logic            rd_equal;
    logic            ref_gt1;   // read entry holds more than one reference
  } stat_t;

endpackage

[rtl/rskt_ram.sv]
module rskt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rskt_datapath.sv]
module rskt_datapath (
  input  logic           clk,
  input  logic           rst,
  input  rskt_pkg::req_t req,
  input  rskt_pkg::cmd_t cmd,
  output rskt_pkg::stat_t stat,
  output rskt_pkg::rsp_t rsp_data
);

  rskt_pkg::req_t   req_q;
  rskt_pkg::entry_t rd_entry;
  rskt_pkg::entry_t held;
  rskt_pkg::entry_t wr_entry;
  logic [rskt_pkg::CntW-1:0] count;
  logic [rskt_pkg::EntW-1:0] rd_raw;

  rskt_ram #(.Width(rskt_pkg::EntW), .Depth(rskt_pkg::Capacity)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = rd_raw;

  // Write data selection.
  always_comb begin
    wr_entry = held;
    case (cmd.wr_sel)
      rskt_pkg::WS_MOVE: wr_entry = rd_entry;
      rskt_pkg::WS_NEW: begin
        wr_entry.key    = req_q.key;
        wr_entry.handle = req_q.data_handle;
        wr_entry.size   = req_q.entry_size;
        wr_entry.refs   = 16'd1;
      end
      rskt_pkg::WS_INC: begin
        if (held.refs != 16'hFFFF) begin
          wr_entry.refs = held.refs + 16'd1;
        end
      end
      rskt_pkg::WS_DEC: wr_entry.refs = held.refs - 16'd1;
      default: wr_entry = held;
    endcase
  end

  // Request, held entry, entry count and response registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.hold_rd) begin
      held <= rd_entry;
    end
    if (cmd.rsp_load) begin
      rsp_data.status <= cmd.rsp_status;
      if (cmd.rsp_status == rskt_pkg::ST_FOUND) begin
        rsp_data.found_handle <= held.handle;
        rsp_data.found_size   <= held.size;
      end else begin
        rsp_data.found_handle <= '0;
        rsp_data.found_size   <= '0;
      end
    end
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  assign stat.operation = req_q.operation;
  assign stat.count     = count;
  assign stat.rd_less   = rd_entry.key < req_q.key;
  assign stat.rd_equal  = rd_entry.key == req_q.key;
  assign stat.ref_gt1   = rd_entry.refs > 16'd1;

endmodule

[rtl/rskt_ctrl.sv]
module rskt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rskt_pkg::stat_t stat,
  output rskt_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SREAD, S_SCMP, S_UPRD, S_UPWR, S_DNRD, S_DNWR, S_RESP
  } state_t;

  state_t state;
  logic [rskt_pkg::CntW-1:0] pos;
  logic [rskt_pkg::CntW-1:0] ptr;
  logic [rskt_pkg::CntW-1:0] pos_p1;
  logic [rskt_pkg::CntW-1:0] ptr_m1;
  logic [rskt_pkg::CntW-1:0] ptr_p1;
  logic [2:0] st_q;
  logic       full;
  logic       up_done;
  logic       dn_done;

  assign pos_p1  = pos + 1'b1;
  assign ptr_m1  = ptr - 1'b1;
  assign ptr_p1  = ptr + 1'b1;
  assign full    = stat.count == rskt_pkg::CntW'(rskt_pkg::Capacity);
  assign up_done = ptr == pos;
  assign dn_done = ptr_p1 >= stat.count;

  // A new request may enter once the previous response is handed over.
  assign in_ready = !rst && (state == S_IDLE) && (!out_valid || out_ready);

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    cmd.load_req   = in_valid && in_ready;
    cmd.rd_addr    = pos[rskt_pkg::IdxW-1:0];
    cmd.wr_addr    = ptr[rskt_pkg::IdxW-1:0];
    cmd.wr_sel     = rskt_pkg::WS_MOVE;
    cmd.rsp_status = st_q;
    unique case (state)
      S_SREAD: begin
        cmd.rd_en = pos < stat.count;
      end
      S_SCMP: begin
        cmd.hold_rd = 1'b1;
      end
      S_UPRD: begin
        // The gap has reached pos: store the new entry there.
        if (up_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = pos[rskt_pkg::IdxW-1:0];
          cmd.wr_sel  = rskt_pkg::WS_NEW;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = ptr_m1[rskt_pkg::IdxW-1:0];
        end
      end
      S_UPWR: begin
        cmd.wr_en = 1'b1;
      end
      S_DNRD: begin
        if (dn_done) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = ptr_p1[rskt_pkg::IdxW-1:0];
        end
      end
      S_DNWR: begin
        cmd.wr_en = 1'b1;
      end
      S_RESP: begin
        cmd.rsp_load = 1'b1;
        cmd.wr_addr  = pos[rskt_pkg::IdxW-1:0];
        if (st_q == rskt_pkg::ST_RAISED) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = rskt_pkg::WS_INC;
        end else if (st_q == rskt_pkg::ST_LOWERED) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = rskt_pkg::WS_DEC;
        end
      end
      default: begin
      end
    endcase
  end

  // State, search position, shift pointer and response handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      ptr       <= '0;
      st_q      <= rskt_pkg::ST_NOT_FOUND;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_valid && in_ready) begin
            pos   <= '0;
            state <= S_SREAD;
          end
        end
        S_SREAD: begin
          if (pos < stat.count) begin
            state <= S_SCMP;
          end else if (stat.operation == rskt_pkg::OP_INSERT) begin
            // Key is past every entry.
            if (full) begin
              st_q  <= rskt_pkg::ST_FULL;
              state <= S_RESP;
            end else begin
              ptr   <= stat.count;
              st_q  <= rskt_pkg::ST_INSERTED;
              state <= S_UPRD;
            end
          end else begin
            st_q  <= rskt_pkg::ST_NOT_FOUND;
            state <= S_RESP;
          end
        end
        S_SCMP: begin
          if (stat.rd_less) begin
            pos   <= pos_p1;
            state <= S_SREAD;
          end else if (stat.rd_equal) begin
            unique case (stat.operation)
              rskt_pkg::OP_INSERT: begin
                st_q  <= rskt_pkg::ST_RAISED;
                state <= S_RESP;
              end
              rskt_pkg::OP_REMOVE: begin
                if (stat.ref_gt1) begin
                  st_q  <= rskt_pkg::ST_LOWERED;
                  state <= S_RESP;
                end else begin
                  st_q  <= rskt_pkg::ST_DELETED;
                  ptr   <= pos;
                  state <= S_DNRD;
                end
              end
              rskt_pkg::OP_LOOKUP: begin
                st_q  <= rskt_pkg::ST_FOUND;
                state <= S_RESP;
              end
              default: begin
                st_q  <= rskt_pkg::ST_NOT_FOUND;
                state <= S_RESP;
              end
            endcase
          end else begin
            // Larger key: the request key belongs here.
            if (stat.operation == rskt_pkg::OP_INSERT) begin
              if (full) begin
                st_q  <= rskt_pkg::ST_FULL;
                state <= S_RESP;
              end else begin
                ptr   <= stat.count;
                st_q  <= rskt_pkg::ST_INSERTED;
                state <= S_UPRD;
              end
            end else begin
              st_q  <= rskt_pkg::ST_NOT_FOUND;
              state <= S_RESP;
            end
          end
        end
        S_UPRD: begin
          // Read entry ptr-1 unless the gap has reached pos.
          if (up_done) begin
            state <= S_RESP;
          end else begin
            state <= S_UPWR;
          end
        end
        S_UPWR: begin
          ptr   <= ptr_m1;
          state <= S_UPRD;
        end
        S_DNRD: begin
          if (dn_done) begin
            state <= S_RESP;
          end else begin
            state <= S_DNWR;
          end
        end
        S_DNWR: begin
          ptr   <= ptr_p1;
          state <= S_DNRD;
        end
        S_RESP: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/refcounted_sorted_key_table.sv]
// Channel | Handshake               | Payload
// in      | in_valid / in_ready     | in_data  (rskt_pkg::req_t)
// out     | out_valid / out_ready   | out_data (rskt_pkg::rsp_t)
//
// One request at a time. A search reads and compares the stored entries in
// key order from position zero until it reaches the request key; an insert or
// delete then moves each shifted entry through the table RAM with a read and
// a write. Reset clears the entry count and the controller state, not the
// table RAM.
// A new request enters in the cycle the previous response is taken.
module refcounted_sorted_key_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rskt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rskt_pkg::rsp_t out_data
);

  rskt_pkg::cmd_t  cmd;
  rskt_pkg::stat_t stat;

  rskt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rskt_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_data (out_data)
  );

  // in_ready is never high while a response is shown and not being taken.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid || out_ready)
    else $error("accept while response blocked");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("response dropped");
  assert property (@(posedge clk) disable iff (rst)
    stat.count <= rskt_pkg::CntW'(rskt_pkg::Capacity))
    else $error("entry count overflow");
  assert property (@(posedge clk) disable iff (rst) !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count moved both ways");

endmodule

[bench/tb_refcounted_sorted_key_table.sv]
module tb_refcounted_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rskt_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rskt_pkg::rsp_t out_data;

  refcounted_sorted_key_table i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the sorted table.
  logic [15:0] tbl_key[rskt_pkg::Capacity];
  logic [31:0] tbl_handle[rskt_pkg::Capacity];
  logic [15:0] tbl_size[rskt_pkg::Capacity];
  logic [15:0] tbl_refs[rskt_pkg::Capacity];
  int tbl_count = 0;

  rskt_pkg::rsp_t pending_rsp[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit quiet_tail = 1'b0;

  // Directed table: request, expected-by-hand flag and expected response.
  typedef struct {
    rskt_pkg::req_t req;
    bit             fixed;
    rskt_pkg::rsp_t rsp;
  } row_t;
  row_t directed[$];

  function automatic int find_slot(logic [15:0] k);
    int p;
    p = 0;
    while (p < tbl_count && tbl_key[p] < k) p++;
    return p;
  endfunction

  // Apply one request to the shadow table and return the response it gives.
  function automatic rskt_pkg::rsp_t table_update(rskt_pkg::req_t r);
    rskt_pkg::rsp_t o;
    int p;
    bit hit;
    o = '0;
    o.status = rskt_pkg::ST_NOT_FOUND;
    p = find_slot(r.key);
    hit = (p < tbl_count) && (tbl_key[p] == r.key);
    case (r.operation)
      rskt_pkg::OP_INSERT: begin
        if (hit) begin
          if (tbl_refs[p] != 16'hFFFF) tbl_refs[p]++;
          o.status = rskt_pkg::ST_RAISED;
        end else if (tbl_count >= rskt_pkg::Capacity) begin
          o.status = rskt_pkg::ST_FULL;
        end else begin
          for (int j = tbl_count; j > p; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_handle[j] = tbl_handle[j-1];
            tbl_size[j] = tbl_size[j-1];
            tbl_refs[j] = tbl_refs[j-1];
          end
          tbl_key[p] = r.key;
          tbl_handle[p] = r.data_handle;
          tbl_size[p] = r.entry_size;
          tbl_refs[p] = 16'd1;
          tbl_count++;
          o.status = rskt_pkg::ST_INSERTED;
        end
      end
      rskt_pkg::OP_REMOVE: begin
        if (hit) begin
          if (tbl_refs[p] > 1) begin
            tbl_refs[p]--;
            o.status = rskt_pkg::ST_LOWERED;
          end else begin
            for (int j = p + 1; j < tbl_count; j++) begin
              tbl_key[j-1] = tbl_key[j];
              tbl_handle[j-1] = tbl_handle[j];
              tbl_size[j-1] = tbl_size[j];
              tbl_refs[j-1] = tbl_refs[j];
            end
            tbl_count--;
            o.status = rskt_pkg::ST_DELETED;
          end
        end
      end
      rskt_pkg::OP_LOOKUP: begin
        if (hit) begin
          o.status = rskt_pkg::ST_FOUND;
          o.found_handle = tbl_handle[p];
          o.found_size = tbl_size[p];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // A gap lowers in_valid, which stays high while requests follow each other.
  task automatic idle_gap();
    if (!quiet_tail && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // Lower in_valid and wait until every expected response has come.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // Present one request and wait for the edge that takes it.
  task automatic send_request(rskt_pkg::req_t r, bit fixed, rskt_pkg::rsp_t fx);
    rskt_pkg::rsp_t p;
    bit rdy;
    p = table_update(r);
    if (fixed && p !== fx) begin
      $error("table row mismatch: expected %h predicted %h", fx, p);
      fail_count++;
    end
    pending_rsp.push_back(fixed ? fx : p);
    in_data <= r;
    in_valid <= 1'b1;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end
  endtask

  function automatic rskt_pkg::req_t mk(logic [1:0] op, logic [15:0] k, logic [31:0] h,
                                        logic [15:0] s);
    rskt_pkg::req_t r;
    r.operation = op;
    r.key = k;
    r.data_handle = h;
    r.entry_size = s;
    return r;
  endfunction

  function automatic rskt_pkg::rsp_t st(logic [2:0] s);
    rskt_pkg::rsp_t o;
    o = '0;
    o.status = s;
    return o;
  endfunction

  // Random key drawn from a small pool so that hits are common.
  function automatic logic [15:0] pick_key(int pool);
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(pool - 1) * 16'd257);
    endcase
  endfunction

  task automatic run_random(int n, int pool, int ins_weight);
    rskt_pkg::req_t r;
    int w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(99);
      if (w < ins_weight) r.operation = rskt_pkg::OP_INSERT;
      else if (w < ins_weight + 25) r.operation = rskt_pkg::OP_REMOVE;
      else if (w < 97) r.operation = rskt_pkg::OP_LOOKUP;
      else r.operation = OpUnused;
      r.key = pick_key(pool);
      r.data_handle = $urandom;
      r.entry_size = 16'($urandom);
      send_request(r, 1'b0, '0);
      idle_gap();
    end
  endtask

  // Response checking with random back-pressure.
  always @(posedge clk) begin
    rskt_pkg::rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          fail_count++;
        end
        if (out_data.found_handle !== e.found_handle) begin
          $error("found_handle expected %h actual %h", e.found_handle,
                 out_data.found_handle);
          fail_count++;
        end
        if (out_data.found_size !== e.found_size) begin
          $error("found_size expected %h actual %h", e.found_size,
                 out_data.found_size);
          fail_count++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left <= $urandom_range(16, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rskt_pkg::rsp_t f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: empty table, extremes, duplicates, unused operation.
    directed.push_back('{mk(rskt_pkg::OP_LOOKUP, 16'h0000, '1, '1), 1,
                         st(rskt_pkg::ST_NOT_FOUND)});
    directed.push_back('{mk(rskt_pkg::OP_REMOVE, 16'hFFFF, '0, '0), 1,
                         st(rskt_pkg::ST_NOT_FOUND)});
    directed.push_back('{mk(rskt_pkg::OP_INSERT, 16'hFFFF, '1, '1), 1,
                         st(rskt_pkg::ST_INSERTED)});
    directed.push_back('{mk(rskt_pkg::OP_INSERT, 16'h0000, '0, '0), 1,
                         st(rskt_pkg::ST_INSERTED)});
    directed.push_back('{mk(rskt_pkg::OP_INSERT, 16'h8000, 32'hA5A5_5A5A, 16'h1234), 1,
                         st(rskt_pkg::ST_INSERTED)});
    directed.push_back('{mk(rskt_pkg::OP_INSERT, 16'h8000, '1, '1), 1,
                         st(rskt_pkg::ST_RAISED)});
    f = st(rskt_pkg::ST_FOUND); f.found_handle = '1; f.found_size = '1;
    directed.push_back('{mk(rskt_pkg::OP_LOOKUP, 16'hFFFF, '0, '0), 1, f});
    f = st(rskt_pkg::ST_FOUND);
    directed.push_back('{mk(rskt_pkg::OP_LOOKUP, 16'h0000, '1, '1), 1, f});
    f = st(rskt_pkg::ST_FOUND); f.found_handle = 32'hA5A5_5A5A; f.found_size = 16'h1234;
    directed.push_back('{mk(rskt_pkg::OP_LOOKUP, 16'h8000, '0, '0), 1, f});
    directed.push_back('{mk(OpUnused, 16'h8000, '1, '1), 1, st(rskt_pkg::ST_NOT_FOUND)});
    directed.push_back('{mk(rskt_pkg::OP_REMOVE, 16'h8000, '1, '1), 1,
                         st(rskt_pkg::ST_LOWERED)});
    directed.push_back('{mk(rskt_pkg::OP_REMOVE, 16'h8000, '0, '0), 1,
                         st(rskt_pkg::ST_DELETED)});
    directed.push_back('{mk(rskt_pkg::OP_LOOKUP, 16'h8000, '0, '0), 1,
                         st(rskt_pkg::ST_NOT_FOUND)});
    directed.push_back('{mk(rskt_pkg::OP_REMOVE, 16'h0000, '0, '0), 1,
                         st(rskt_pkg::ST_DELETED)});
    directed.push_back('{mk(rskt_pkg::OP_INSERT, 16'h4000, 32'h1, 16'h2), 0, '0});
    directed.push_back('{mk(rskt_pkg::OP_LOOKUP, 16'h4000, '0, '0), 0, '0});
    directed.push_back('{mk(rskt_pkg::OP_REMOVE, 16'hFFFF, '0, '0), 1,
                         st(rskt_pkg::ST_DELETED)});
    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].fixed, directed[i].rsp);
      idle_gap();
    end

    // Mixed random traffic over a small key pool.
    run_random(300, 24, 40);

    // Hold off until the block has drained.
    wait_drain();

    // Fill the table to capacity, then hit it with new and present keys.
    for (int i = 0; tbl_count < rskt_pkg::Capacity; i++) begin
      send_request(mk(rskt_pkg::OP_INSERT, 16'(i * 251 + 7), $urandom, 16'($urandom)),
                   1'b0, '0);
      if (i % 8 == 0) idle_gap();
    end
    send_request(mk(rskt_pkg::OP_INSERT, 16'h0003, '1, '1), 1'b0, '0);
    send_request(mk(rskt_pkg::OP_INSERT, tbl_key[0], '1, '1), 1'b0, '0);
    send_request(mk(rskt_pkg::OP_INSERT, tbl_key[rskt_pkg::Capacity-1], '1, '1), 1'b0, '0);
    send_request(mk(rskt_pkg::OP_LOOKUP, tbl_key[rskt_pkg::Capacity-1], '0, '0), 1'b0, '0);

    // Random traffic near full, mostly existing keys.
    for (int i = 0; i < 150; i++) begin
      send_request(mk(2'($urandom_range(2)),
                      $urandom_range(3) == 0 ? 16'($urandom)
                                             : tbl_key[$urandom_range(tbl_count - 1)],
                      $urandom, 16'($urandom)), 1'b0, '0);
      idle_gap();
    end

    // Drain by removing everything that is left.
    while (tbl_count > 0)
      send_request(mk(rskt_pkg::OP_REMOVE, tbl_key[$urandom_range(tbl_count - 1)],
                      '0, '0), 1'b0, '0);

    // Final part with no idling.
    quiet_tail = 1'b1;
    run_random(200, 16, 45);

    wait_drain();
    repeat (4 * rskt_pkg::Capacity + 20) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
